/* rtl/tlc_pkg.sv */
`default_nettype none
package tlc_pkg;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [2:0] REG_L1_SB = 3'd0;
  localparam logic [2:0] REG_L2_SB = 3'd1;
  localparam logic [2:0] REG_L3_SB = 3'd2;
  localparam logic [2:0] REG_L1_WAYS = 3'd3;
  localparam logic [2:0] REG_L2_WAYS = 3'd4;
  localparam logic [2:0] REG_L3_WAYS = 3'd5;
  localparam logic [2:0] REG_BLK = 3'd6;
  localparam logic [2:0] REG_LRU = 3'd7;

  typedef enum logic [1:0] {
    OUT_HIT  = 2'd0,
    OUT_COLD = 2'd1,
    OUT_CONF = 2'd2,
    OUT_SKIP = 2'd3
  } outcome_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_NEXT,
    ST_DONE
  } state_e;

  // level controller handshake
  typedef struct packed {
    logic start;
    logic do_fill;
  } lvl_cmd_t;

  typedef struct packed {
    logic     done;
    outcome_e outcome;
  } lvl_rsp_t;
endpackage
`default_nettype wire

/* rtl/three_level_cache_hit_classifier_unit.sv */
`default_nettype none
// Three-level cache hit classifier. Each address request is probed against
// level one, then level two and three on a miss; every missing level is
// filled (free way first, else oldest by FIFO or LRU rank). Each level keeps
// one row per set (all ways: valid, age rank, tag) in a synchronous RAM, so
// a level takes a read step (READ or NEXT) and an evaluate/write-back
// step (EVAL): IDLE, READ, EVAL for level one, then NEXT, EVAL per further
// level, and the result is held in DONE until taken. After reset a clearing
// pass over max(L1,L2,L3)_SETS_MAX rows (one row per cycle in all levels at
// once) runs before the first request is taken.
module three_level_cache_hit_classifier_unit
  import tlc_pkg::*;
#(
  parameter int unsigned L1_SETS_MAX = 64,
  parameter int unsigned L2_SETS_MAX = 512,
  parameter int unsigned L3_SETS_MAX = 4096,
  parameter int unsigned WAYS_MAX = 8,
  parameter int unsigned ADDR_BITS = 48
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [47:0]           address_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [1:0]                 l1_outcome_o,
  output logic [1:0]                 l2_outcome_o,
  output logic [1:0]                 l3_outcome_o
);
  localparam int unsigned M12 = (L1_SETS_MAX > L2_SETS_MAX) ? L1_SETS_MAX : L2_SETS_MAX;
  localparam int unsigned CLR_N = (M12 > L3_SETS_MAX) ? M12 : L3_SETS_MAX;
  localparam int unsigned CLR_W = $clog2(CLR_N + 1);
  localparam int unsigned L1_CW = $clog2(L1_SETS_MAX + 1);
  localparam int unsigned L2_CW = $clog2(L2_SETS_MAX + 1);
  localparam int unsigned L3_CW = $clog2(L3_SETS_MAX + 1);

  // configuration registers
  logic [2:0] l1_sb_q;
  logic [3:0] l2_sb_q, l3_sb_q, l1_ways_q, l2_ways_q, l3_ways_q, blk_q;
  logic       lru_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_sb_q <= '0; l2_sb_q <= '0; l3_sb_q <= '0;
      l1_ways_q <= 4'd1; l2_ways_q <= 4'd1; l3_ways_q <= 4'd1;
      blk_q <= 4'd6; lru_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_L1_SB:   l1_sb_q   <= cfg_data_i[2:0];
        REG_L2_SB:   l2_sb_q   <= cfg_data_i;
        REG_L3_SB:   l3_sb_q   <= cfg_data_i;
        REG_L1_WAYS: l1_ways_q <= cfg_data_i;
        REG_L2_WAYS: l2_ways_q <= cfg_data_i;
        REG_L3_WAYS: l3_ways_q <= cfg_data_i;
        REG_BLK:     blk_q     <= cfg_data_i;
        REG_LRU:     lru_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer
  state_e     state_q, state_d;
  logic [1:0] lvl_q, lvl_d;
  logic [CLR_W-1:0] clr_q, clr_d;
  logic [ADDR_BITS-1:0] blk_addr_q, blk_addr_d;
  outcome_e o1_q, o2_q, o3_q, o1_d, o2_d, o3_d;
  lvl_cmd_t cmd [3];
  lvl_rsp_t rsp [3];
  outcome_e cur;
  logic [47:0] abits;

  assign abits = address_i;

  always_comb begin
    state_d = state_q; lvl_d = lvl_q; clr_d = clr_q; blk_addr_d = blk_addr_q;
    o1_d = o1_q; o2_d = o2_q; o3_d = o3_q;
    cur = rsp[lvl_q].outcome;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == CLR_W'(CLR_N - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          blk_addr_d = ADDR_BITS'(abits) >> blk_q;
          lvl_d = 2'd0; state_d = ST_READ;
          o1_d = OUT_SKIP; o2_d = OUT_SKIP; o3_d = OUT_SKIP;
        end
      end
      ST_READ: state_d = ST_EVAL;
      ST_EVAL: begin
        case (lvl_q)
          2'd0: o1_d = cur;
          2'd1: o2_d = cur;
          default: o3_d = cur;
        endcase
        if (cur != OUT_HIT && lvl_q != 2'd2) begin
          lvl_d = lvl_q + 1'b1; state_d = ST_NEXT;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_NEXT: state_d = ST_EVAL;
      ST_DONE: if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // level commands: a level is read in READ/NEXT of its turn, fills on a miss
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmd[i].start   = ((state_q == ST_READ && i == 0) ||
                        (state_q == ST_NEXT && 2'(i) == lvl_q));
      cmd[i].do_fill = 1'b1;
    end
    in_ready_o   = (state_q == ST_IDLE);
    out_valid_o  = (state_q == ST_DONE);
    l1_outcome_o = o1_q;
    l2_outcome_o = o2_q;
    l3_outcome_o = o3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; lvl_q <= '0; clr_q <= '0;
    end else begin
      state_q <= state_d; lvl_q <= lvl_d; clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_addr_q <= blk_addr_d;
    o1_q <= o1_d; o2_q <= o2_d; o3_q <= o3_d;
  end

  logic clr;
  assign clr = (state_q == ST_CLEAR);

  tlc_level #(.SETS_MAX(L1_SETS_MAX), .WAYS_MAX(WAYS_MAX), .ADDR_BITS(ADDR_BITS)) u_l1 (
    .clk_i, .rst_ni, .clr_i(clr), .clr_idx_i(L1_CW'(clr_q)),
    .blk_i(blk_addr_q), .sb_i({1'b0, l1_sb_q}), .ways_i(l1_ways_q), .lru_i(lru_q),
    .cmd_i(cmd[0]), .rsp_o(rsp[0]));
  tlc_level #(.SETS_MAX(L2_SETS_MAX), .WAYS_MAX(WAYS_MAX), .ADDR_BITS(ADDR_BITS)) u_l2 (
    .clk_i, .rst_ni, .clr_i(clr), .clr_idx_i(L2_CW'(clr_q)),
    .blk_i(blk_addr_q), .sb_i(l2_sb_q), .ways_i(l2_ways_q), .lru_i(lru_q),
    .cmd_i(cmd[1]), .rsp_o(rsp[1]));
  tlc_level #(.SETS_MAX(L3_SETS_MAX), .WAYS_MAX(WAYS_MAX), .ADDR_BITS(ADDR_BITS)) u_l3 (
    .clk_i, .rst_ni, .clr_i(clr), .clr_idx_i(L3_CW'(clr_q)),
    .blk_i(blk_addr_q), .sb_i(l3_sb_q), .ways_i(l3_ways_q), .lru_i(lru_q),
    .cmd_i(cmd[2]), .rsp_o(rsp[2]));
endmodule
`default_nettype wire

/* rtl/tlc_ram.sv */
`default_nettype none
module tlc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

/* rtl/tlc_level.sv */
`default_nettype none
module tlc_level
  import tlc_pkg::*;
#(
  parameter int unsigned SETS_MAX = 64,
  parameter int unsigned WAYS_MAX = 8,
  parameter int unsigned ADDR_BITS = 48
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 clr_i,
  input  wire logic [$clog2(SETS_MAX+1)-1:0] clr_idx_i,
  input  wire logic [ADDR_BITS-1:0] blk_i,
  input  wire logic [3:0]           sb_i,
  input  wire logic [3:0]           ways_i,
  input  wire logic                 lru_i,
  input  wire lvl_cmd_t             cmd_i,
  output lvl_rsp_t                  rsp_o
);
  localparam int unsigned SET_W = (SETS_MAX > 1) ? $clog2(SETS_MAX) : 1;
  localparam int unsigned RANK_W = (WAYS_MAX > 1) ? $clog2(WAYS_MAX) : 1;
  localparam int unsigned WAY_W = $clog2(WAYS_MAX + 1);
  localparam int unsigned ENT_W = 1 + RANK_W + ADDR_BITS;
  localparam int unsigned ROW_W = WAYS_MAX * ENT_W;
  localparam int unsigned SB_MAX = $clog2(SETS_MAX);

  typedef struct packed {
    logic              valid;
    logic [RANK_W-1:0] rank;
    logic [ADDR_BITS-1:0] tag;
  } ent_t;

  logic [3:0]           sb_eff;
  logic [WAY_W-1:0]     ways_eff;
  logic [SET_W-1:0]     set_idx;
  logic [ADDR_BITS-1:0] key;
  logic [ADDR_BITS-1:0] set_mask;

  always_comb begin
    sb_eff = (32'(sb_i) > SB_MAX) ? 4'(SB_MAX) : sb_i;
    if (ways_i == 4'd0) begin
      ways_eff = WAY_W'(1);
    end else if (32'(ways_i) > WAYS_MAX) begin
      ways_eff = WAY_W'(WAYS_MAX);
    end else begin
      ways_eff = WAY_W'(ways_i);
    end
    set_mask = ~({ADDR_BITS{1'b1}} << sb_eff);
    set_idx  = SET_W'(blk_i & set_mask);
    key      = blk_i >> sb_eff;
  end

  // one row holds all ways of a set
  logic             we;
  logic [SET_W-1:0] waddr;
  logic [ROW_W-1:0] wdata, rdata;
  logic             eval_q;

  tlc_ram #(.WIDTH(ROW_W), .DEPTH(2 ** SET_W)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(set_idx),
    .rdata_o(rdata)
  );

  ent_t             row  [WAYS_MAX];
  ent_t             nrow [WAYS_MAX];
  logic             hit, free;
  logic [WAY_W-1:0] hit_w, fill_w, vic_w, sel_w;
  logic [RANK_W-1:0] old_rank;
  logic             sel_valid, upd;
  logic [RANK_W:0]  others;
  outcome_e         outc;

  always_comb begin
    for (int j = 0; j < WAYS_MAX; j++) begin
      row[j] = ent_t'(rdata[j*ENT_W +: ENT_W]);
    end
    hit = 1'b0; free = 1'b0; hit_w = '0; fill_w = '0;
    for (int j = WAYS_MAX-1; j >= 0; j--) begin
      if (WAY_W'(j) < ways_eff) begin
        if (!row[j].valid) begin
          free = 1'b1; fill_w = WAY_W'(j);
        end
      end
    end
    for (int j = WAYS_MAX-1; j >= 0; j--) begin
      if (WAY_W'(j) < ways_eff && row[j].valid && row[j].tag == key) begin
        hit = 1'b1; hit_w = WAY_W'(j);
      end
    end
    vic_w = '0;
    for (int j = 1; j < WAYS_MAX; j++) begin
      if (WAY_W'(j) < ways_eff && row[j].rank < row[vic_w[RANK_W-1:0]].rank) begin
        vic_w = WAY_W'(j);
      end
    end
    // first-match hit also needs no earlier free way rule; cold only on miss
    outc = hit ? OUT_HIT : (free ? OUT_COLD : OUT_CONF);
    sel_w     = hit ? hit_w : (free ? fill_w : vic_w);
    sel_valid = hit || !free;
    upd       = hit ? lru_i : cmd_i.do_fill;
    old_rank  = row[sel_w[RANK_W-1:0]].rank;
    others    = '0;
    for (int j = 0; j < WAYS_MAX; j++) begin
      nrow[j] = row[j];
      if (WAY_W'(j) < ways_eff && WAY_W'(j) != sel_w && row[j].valid) begin
        others = others + 1'b1;
        if (sel_valid && row[j].rank > old_rank) begin
          nrow[j].rank = row[j].rank - 1'b1;
        end
      end
    end
    nrow[sel_w[RANK_W-1:0]].rank  = others[RANK_W-1:0];
    nrow[sel_w[RANK_W-1:0]].valid = 1'b1;
    if (!hit) begin
      nrow[sel_w[RANK_W-1:0]].tag = key;
    end
    for (int j = 0; j < WAYS_MAX; j++) begin
      wdata[j*ENT_W +: ENT_W] = nrow[j];
    end
    if (clr_i) begin
      we = 1'b1; waddr = SET_W'(clr_idx_i); wdata = '0;
    end else begin
      we = eval_q && upd; waddr = set_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_q <= 1'b0;
    end else begin
      eval_q <= cmd_i.start;
    end
  end

  assign rsp_o.done    = eval_q;
  assign rsp_o.outcome = outc;
endmodule
`default_nettype wire

/* tb/sv/three_level_cache_hit_classifier_unit_tb.sv */
`timescale 1ns / 1ps
module three_level_cache_hit_classifier_unit_tb;
  import tlc_pkg::*;

  localparam int unsigned L1_SETS = 64;
  localparam int unsigned L2_SETS = 512;
  localparam int unsigned L3_SETS = 4096;
  localparam int unsigned WAYS = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic req_valid;
  logic req_ready;
  logic [47:0] req_addr;
  logic rsp_valid;
  logic rsp_ready;
  logic [1:0] l1_out, l2_out, l3_out;

  three_level_cache_hit_classifier_unit dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data),
    .in_valid_i(req_valid),
    .in_ready_o(req_ready),
    .address_i(req_addr),
    .out_valid_o(rsp_valid),
    .out_ready_i(rsp_ready),
    .l1_outcome_o(l1_out),
    .l2_outcome_o(l2_out),
    .l3_outcome_o(l3_out)
  );

  typedef struct packed {
    outcome_e o1;
    outcome_e o2;
    outcome_e o3;
  } verdict_t;

  // shadow cache contents, tag, valid and age arrays per level (set * WAYS + way)
  logic [47:0] tag1 [L1_SETS*WAYS];
  logic [47:0] tag2 [L2_SETS*WAYS];
  logic [47:0] tag3 [L3_SETS*WAYS];
  bit vld1 [L1_SETS*WAYS];
  bit vld2 [L2_SETS*WAYS];
  bit vld3 [L3_SETS*WAYS];
  int unsigned age1 [L1_SETS*WAYS];
  int unsigned age2 [L2_SETS*WAYS];
  int unsigned age3 [L3_SETS*WAYS];

  // shadow registers
  logic [3:0] sb_cfg [3];
  logic [3:0] ways_cfg [3];
  logic [3:0] blk_cfg;
  bit lru_on;

  logic [47:0] pending_reqs [$];
  verdict_t expected_verdicts [$];
  bit failed;
  int unsigned cycles;
  int unsigned send_idle_pct, recv_idle_pct;
  bit sender_hold;

  // working view of the set addressed in one level
  int unsigned lv;
  int unsigned base;
  int unsigned nways;
  logic [47:0] key;

  function automatic bit vld_get(int unsigned e);
    case (lv)
      0: return vld1[e];
      1: return vld2[e];
      default: return vld3[e];
    endcase
  endfunction

  function automatic int unsigned age_get(int unsigned e);
    case (lv)
      0: return age1[e];
      1: return age2[e];
      default: return age3[e];
    endcase
  endfunction

  function automatic logic [47:0] tag_get(int unsigned e);
    case (lv)
      0: return tag1[e];
      1: return tag2[e];
      default: return tag3[e];
    endcase
  endfunction

  task automatic age_set(int unsigned e, int unsigned a);
    case (lv)
      0: age1[e] = a;
      1: age2[e] = a;
      default: age3[e] = a;
    endcase
  endtask

  task automatic select_set(int unsigned l, logic [47:0] blk);
    int unsigned sb;
    int unsigned smax;
    lv = l;
    smax = (l == 0) ? L1_SETS : (l == 1) ? L2_SETS : L3_SETS;
    sb = sb_cfg[l];
    while (sb > 0 && (64'd1 << sb) > smax) sb--;
    nways = (ways_cfg[l] == 0) ? 1 : (ways_cfg[l] > WAYS) ? WAYS : ways_cfg[l];
    base = 32'((blk & ((48'd1 << sb) - 48'd1)) * WAYS);
    key = blk >> sb;
  endtask

  // move way w to the young end of the age order
  task automatic promote_way(int unsigned w, bit was_valid);
    int unsigned others;
    int unsigned old;
    others = 0;
    old = was_valid ? age_get(base + w) : 255;
    for (int unsigned j = 0; j < nways; j++) begin
      if (j != w && vld_get(base + j)) begin
        others++;
        if (age_get(base + j) > old) age_set(base + j, age_get(base + j) - 1);
      end
    end
    age_set(base + w, others);
  endtask

  task automatic probe_level(output outcome_e res);
    bit free_way;
    free_way = 0;
    for (int unsigned j = 0; j < nways; j++) begin
      if (!vld_get(base + j)) begin
        free_way = 1;
      end else if (tag_get(base + j) == key) begin
        if (lru_on) promote_way(j, 1);
        res = OUT_HIT;
        return;
      end
    end
    res = free_way ? OUT_COLD : OUT_CONF;
  endtask

  task automatic fill_level();
    int unsigned w;
    bit found;
    w = 0;
    found = 0;
    for (int unsigned j = 0; j < nways && !found; j++)
      if (!vld_get(base + j)) begin
        w = j;
        found = 1;
      end
    if (found) begin
      promote_way(w, 0);
    end else begin
      for (int unsigned j = 1; j < nways; j++)
        if (age_get(base + j) < age_get(base + w)) w = j;
      promote_way(w, 1);
    end
    case (lv)
      0: begin vld1[base + w] = 1; tag1[base + w] = key; end
      1: begin vld2[base + w] = 1; tag2[base + w] = key; end
      default: begin vld3[base + w] = 1; tag3[base + w] = key; end
    endcase
  endtask

  task automatic classify_access(logic [47:0] addr, output verdict_t v);
    logic [47:0] blk;
    blk = addr >> blk_cfg;
    v.o2 = OUT_SKIP;
    v.o3 = OUT_SKIP;
    select_set(0, blk);
    probe_level(v.o1);
    if (v.o1 != OUT_HIT) begin
      select_set(1, blk);
      probe_level(v.o2);
      if (v.o2 != OUT_HIT) begin
        select_set(2, blk);
        probe_level(v.o3);
        if (v.o3 != OUT_HIT) fill_level();
        select_set(1, blk);
        fill_level();
      end
      select_set(0, blk);
      fill_level();
    end
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // request driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_valid <= 0;
      req_addr <= '0;
    end else if (!req_valid || req_ready) begin
      if (pending_reqs.size() > 0 && !sender_hold &&
          $urandom_range(99) >= send_idle_pct) begin
        verdict_t v;
        classify_access(pending_reqs[0], v);
        expected_verdicts.push_back(v);
        req_addr <= pending_reqs.pop_front();
        req_valid <= 1;
      end else begin
        req_valid <= 0;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_ready <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t unexpected result %0d %0d %0d", $time, l1_out, l2_out, l3_out);
          failed = 1;
        end else begin
          verdict_t v;
          v = expected_verdicts.pop_front();
          if (l1_out !== v.o1) begin
            $display("%0t l1_outcome expected %0d actual %0d", $time, v.o1, l1_out);
            failed = 1;
          end
          if (l2_out !== v.o2) begin
            $display("%0t l2_outcome expected %0d actual %0d", $time, v.o2, l2_out);
            failed = 1;
          end
          if (l3_out !== v.o3) begin
            $display("%0t l3_outcome expected %0d actual %0d", $time, v.o3, l3_out);
            failed = 1;
          end
        end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[three_level_cache_hit_classifier_unit] ERROR");
      $finish;
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_verdicts.size() > 0 || req_valid)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [3:0] val);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_L1_SB: sb_cfg[0] = val & 4'd7;
      REG_L2_SB: sb_cfg[1] = val;
      REG_L3_SB: sb_cfg[2] = val;
      REG_L1_WAYS: ways_cfg[0] = val;
      REG_L2_WAYS: ways_cfg[1] = val;
      REG_L3_WAYS: ways_cfg[2] = val;
      REG_BLK: blk_cfg = val;
      REG_LRU: lru_on = val[0];
      default: ;
    endcase
  endtask

  task automatic setup(int unsigned s1, s2, s3, w1, w2, w3, blk, lru);
    write_reg(REG_L1_SB, 4'(s1));
    write_reg(REG_L2_SB, 4'(s2));
    write_reg(REG_L3_SB, 4'(s3));
    write_reg(REG_L1_WAYS, 4'(w1));
    write_reg(REG_L2_WAYS, 4'(w2));
    write_reg(REG_L3_WAYS, 4'(w3));
    write_reg(REG_BLK, 4'(blk));
    write_reg(REG_LRU, 4'(lru));
    cfg_we <= 0;
  endtask

  // addresses from a small working set so hits and evictions both occur
  task automatic queue_random(int unsigned n);
    logic [47:0] hot [16];
    for (int i = 0; i < 16; i++) hot[i] = 48'({$urandom, $urandom});
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8)
        pending_reqs.push_back(hot[$urandom_range(15)] ^ ($urandom_range(63) << 4));
      else
        pending_reqs.push_back(48'({$urandom, $urandom}));
    end
  endtask

  initial begin
    for (int i = 0; i < L1_SETS*WAYS; i++) begin vld1[i] = 0; age1[i] = 0; end
    for (int i = 0; i < L2_SETS*WAYS; i++) begin vld2[i] = 0; age2[i] = 0; end
    for (int i = 0; i < L3_SETS*WAYS; i++) begin vld3[i] = 0; age3[i] = 0; end
    sb_cfg = '{0, 0, 0};
    ways_cfg = '{1, 1, 1};
    blk_cfg = 6;
    lru_on = 0;
    failed = 0;
    cycles = 0;
    sender_hold = 0;
    send_idle_pct = 12;
    recv_idle_pct = 58;
    cfg_we = 0;
    cfg_idx = '0;
    cfg_data = '0;
    rst_n = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset config, extremes of the address, repeats for hits
    pending_reqs.push_back(48'h0);
    pending_reqs.push_back(48'h0);
    pending_reqs.push_back(48'hFFFF_FFFF_FFFF);
    pending_reqs.push_back(48'hFFFF_FFFF_FFC0);
    pending_reqs.push_back(48'h0000_0000_0040);
    pending_reqs.push_back(48'h0);
    pending_reqs.push_back(48'hAAAA_AAAA_AAAA);
    pending_reqs.push_back(48'h5555_5555_5555);
    drain();

    // out-of-range set bits and ways, zero ways, LRU on
    setup(7, 15, 15, 0, 15, 8, 0, 1);
    for (int i = 0; i < 12; i++) pending_reqs.push_back(48'h1000 * (i % 5));
    pending_reqs.push_back(48'hFFFF_FFFF_FFFF);
    drain();

    // fully associative small levels, LRU, big blocks
    setup(0, 0, 0, 2, 4, 8, 12, 1);
    queue_random(600);
    // pause the sender until everything is back
    while (pending_reqs.size() > 0) @(posedge clk);
    sender_hold = 1;
    drain();
    sender_hold = 0;

    send_idle_pct = 58;
    recv_idle_pct = 12;
    setup(6, 9, 12, 8, 8, 8, 4, 0);
    queue_random(300);
    drain();
    setup(2, 3, 4, 1, 2, 3, 6, 1);
    queue_random(300);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    setup(1, 2, 2, 4, 1, 2, 0, 0);
    queue_random(600);
    drain();

    if (!failed) begin
      $display("[three_level_cache_hit_classifier_unit] OK");
    end else begin
      $display("[three_level_cache_hit_classifier_unit] ERROR");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/tlc_pkg.sv
rtl/tlc_ram.sv
rtl/tlc_level.sv
rtl/three_level_cache_hit_classifier_unit.sv
tb/sv/three_level_cache_hit_classifier_unit_tb.sv
